FILE: rtl/lfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types for the lfu key/value cache
// ----------------------------------------------------------------------------
package lfu_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_OUT
	} state_t;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

endpackage
`default_nettype wire

FILE: rtl/lfu_key_value_cache_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_key_value_cache_unit
// fully associative lfu key/value cache with lru tie break
// ----------------------------------------------------------------------------
// a new request is taken only in idle, after the last result is accepted;
// each runs a serial scan and a serial write-back of the entry memory
// (one entry read per cycle) with a decide step between them
// reset: all entries invalid, capacity limit 16; no clearing pass
module lfu_key_value_cache_unit
	import lfu_pkg::*;
#(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        opcode,
	input  wire logic [31:0] lookup_key,
	input  wire logic [31:0] write_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             hit,
	output logic [31:0]      read_value,
	output logic             evicted,
	output logic [31:0]      evicted_key
);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = IW;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	typedef struct packed {
		logic [31:0]           key;
		logic [31:0]           value;
		logic [COUNT_BITS-1:0] count;
		logic [RW-1:0]         rank;
	} entry_t;

	entry_t           mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	entry_t           rd_q;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr, mem_raddr;
	entry_t           mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	state_t state_q, state_d;
	logic [4:0]    cap_q;
	logic          op_q;
	logic [31:0]   key_q, val_q;
	logic [CW-1:0] idx_q;     // address issued
	logic [CW-1:0] ridx_q;    // address of rd_q
	logic          rvld_q;
	logic          found_q;
	logic [IW-1:0] found_i_q;
	entry_t        found_e_q;
	logic [CW-1:0] used_q;
	logic          vic_ok_q;
	logic [IW-1:0] vic_i_q;
	entry_t        vic_e_q;
	logic          free_ok_q;
	logic [IW-1:0] free_i_q;
	// decided action
	logic          do_q;      // modify anything
	logic          ins_q;     // insert path
	logic          ev_q;
	logic [IW-1:0] slot_q;
	logic [RW-1:0] ref_r_q;   // touch rank or evicted rank
	logic          hit_q, evd_q;
	logic [31:0]   rv_q, evk_q;

	logic [CW-1:0] cap_eff;
	assign cap_eff = (int'(cap_q) > ENTRIES) ? CW'(ENTRIES) : CW'(cap_q);

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign hit = hit_q;
	assign read_value = rv_q;
	assign evicted = evd_q;
	assign evicted_key = evk_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN:   if (rvld_q && ridx_q == CW'(ENTRIES - 1)) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_UPDATE;
			ST_UPDATE: if (rvld_q && ridx_q == CW'(ENTRIES - 1)) state_d = ST_OUT;
			ST_OUT:    if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// write-back of entry at ridx_q during update
	logic [IW-1:0] ri;
	logic          rv;
	entry_t        upd;
	logic          upd_we;
	assign ri = ridx_q[IW-1:0];
	assign rv = valid_q[ri];

	always_comb begin
		upd = rd_q;
		upd_we = 1'b0;
		if (do_q && !ins_q) begin
			if (ri == slot_q) begin
				upd.rank = '0;
				if (rd_q.count != CMAX) upd.count = rd_q.count + 1'b1;
				if (op_q == OP_PUT) upd.value = val_q;
				upd_we = 1'b1;
			end else if (rv && rd_q.rank < ref_r_q) begin
				upd.rank = rd_q.rank + 1'b1;
				upd_we = 1'b1;
			end
		end else if (do_q && ins_q) begin
			if (ri == slot_q) begin
				upd.key = key_q;
				upd.value = val_q;
				upd.count = COUNT_BITS'(1);
				upd.rank = '0;
				upd_we = 1'b1;
			end else if (rv) begin
				if (ev_q && rd_q.rank > ref_r_q) upd.rank = rd_q.rank;
				else upd.rank = rd_q.rank + 1'b1;
				upd_we = 1'b1;
			end
		end
	end

	always_comb begin
		mem_raddr = idx_q[IW-1:0];
		mem_we = (state_q == ST_UPDATE) && rvld_q && upd_we;
		mem_waddr = ri;
		mem_wdata = upd;
	end

	logic better;
	assign better = !vic_ok_q || rd_q.count < vic_e_q.count ||
		(rd_q.count == vic_e_q.count && rd_q.rank > vic_e_q.rank);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q <= 5'd16;
			valid_q <= '0;
			rvld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cap_q <= cfg_wdata;
			rvld_q <= 1'b0;
			case (state_q)
				ST_IDLE: idx_q <= '0;
				ST_SCAN, ST_UPDATE: begin
					if (idx_q != CW'(ENTRIES)) begin
						rvld_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DECIDE: idx_q <= '0;
				ST_OUT: begin
					idx_q <= '0;
					if (do_q && ins_q) valid_q[slot_q] <= 1'b1;
				end
				default: idx_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_q <= idx_q;
		case (state_q)
			ST_IDLE: begin
				op_q <= opcode;
				key_q <= lookup_key;
				val_q <= write_value;
				found_q <= 1'b0;
				vic_ok_q <= 1'b0;
				free_ok_q <= 1'b0;
				used_q <= '0;
			end
			ST_SCAN: begin
				if (rvld_q) begin
					if (rv) begin
						used_q <= used_q + 1'b1;
						if (!found_q && rd_q.key == key_q) begin
							found_q <= 1'b1;
							found_i_q <= ri;
							found_e_q <= rd_q;
						end
						if (better) begin
							vic_ok_q <= 1'b1;
							vic_i_q <= ri;
							vic_e_q <= rd_q;
						end
					end else if (!free_ok_q) begin
						free_ok_q <= 1'b1;
						free_i_q <= ri;
					end
				end
			end
			ST_DECIDE: begin
				hit_q <= 1'b0;
				rv_q <= '1;
				evd_q <= 1'b0;
				evk_q <= '0;
				do_q <= 1'b0;
				ins_q <= 1'b0;
				ev_q <= 1'b0;
				if (!(op_q == OP_PUT && cap_eff == '0)) begin
					if (found_q) begin
						hit_q <= 1'b1;
						rv_q <= found_e_q.value;
						do_q <= 1'b1;
						slot_q <= found_i_q;
						ref_r_q <= found_e_q.rank;
					end else if (op_q == OP_PUT) begin
						if (used_q >= cap_eff && vic_ok_q) begin
							evd_q <= 1'b1;
							evk_q <= vic_e_q.key;
							do_q <= 1'b1;
							ins_q <= 1'b1;
							ev_q <= 1'b1;
							slot_q <= vic_i_q;
							ref_r_q <= vic_e_q.rank;
						end else if (free_ok_q) begin
							do_q <= 1'b1;
							ins_q <= 1'b1;
							slot_q <= free_i_q;
						end
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
